/* rtl/swsub_pkg.sv */
package swsub_pkg;

    // Largest segment count, and the bits needed to hold it
    localparam int MaxSeg = 63;
    localparam int NW     = 6;

    localparam logic [30:0] SpacingReset = 31'd65536;
    localparam logic [15:0] QuatOne      = 16'd16384;

    // One classified segment, handed from the front end to the emitter
    typedef struct packed {
        logic [2:0][31:0] start;
        logic [2:0]       neg;
        logic [2:0][31:0] qd;
        logic [2:0][5:0]  rd;
        logic [5:0]       n;
        logic             clamped;
        logic [15:0]      qz;
        logic [15:0]      qw;
        logic [15:0]      eqx;
        logic [15:0]      eqy;
        logic [15:0]      eqz;
        logic [15:0]      eqw;
    } t_seg;

endpackage

/* rtl/swsub_front.sv */
module swsub_front import swsub_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic [30:0] i_spacing,
    input  logic        i_push,
    output logic        o_full,
    input  logic [31:0] i_start_x,
    input  logic [31:0] i_start_y,
    input  logic [31:0] i_start_z,
    input  logic [31:0] i_end_x,
    input  logic [31:0] i_end_y,
    input  logic [31:0] i_end_z,
    input  logic [15:0] i_end_qx,
    input  logic [15:0] i_end_qy,
    input  logic [15:0] i_end_qz,
    input  logic [15:0] i_end_qw,
    output logic        o_q_push,
    input  logic        i_q_full,
    output t_seg        o_q_data
);

    typedef enum logic [3:0] {
        S_IDLE, S_SQ, S_NSRCH, S_DIV, S_NORM, S_SQ2, S_SQRT, S_HALF, S_PUSH
    } t_state;

    t_state              r_state;
    logic [4:0]          r_cnt;
    logic [31:0]         r_start [3];
    logic signed [32:0]  r_d     [3];
    logic [15:0]         r_eq    [4];
    logic [65:0]         r_len2;
    logic [61:0]         r_sp2;
    logic [73:0]         r_t2;
    logic [67:0]         r_u;
    logic [5:0]          r_k;
    logic [5:0]          r_n;
    logic                r_clamp;
    logic [31:0]         r_dvd   [3];
    logic [5:0]          r_rem   [3];
    logic [31:0]         r_ax;
    logic [31:0]         r_ay;
    logic [63:0]         r_v;
    logic [63:0]         r_res;
    logic [63:0]         r_bit;
    logic [31:0]         r_r;
    logic [32:0]         r_pos;
    logic [32:0]         r_neg;
    logic [14:0]         r_val;
    logic [3:0]          r_b;
    logic [1:0]          r_ph;
    logic                r_h;
    logic [15:0]         r_qz;
    logic [15:0]         r_qw;
    logic [63:0]         r_prod;

    logic [31:0] mul_a, mul_b;
    logic [30:0] sp;
    logic [14:0] cand;
    logic [15:0] tw;
    logic [61:0] lim;
    logic        keep;
    logic [14:0] val_nx;
    logic [63:0] trial;
    logic        take;
    logic [63:0] res_nx;
    logic [31:0] m;
    logic [31:0] mg [3];

    function automatic logic [31:0] mag33(logic signed [32:0] v);
        logic [32:0] a;
        a = v[32] ? 33'(-v) : 33'(v);
        return a[31:0];
    endfunction

    assign sp = (i_spacing == '0) ? 31'd1 : i_spacing;

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            mg[a] = mag33(r_d[a]);
        end
    end

    // Half-angle search candidate
    assign cand   = r_val | (15'd1 << r_b);
    assign tw     = {cand, 1'b0} - 16'd1;
    assign lim    = {(r_h ? r_neg : r_pos), 29'b0};
    assign keep   = (r_ph == 2'd2) && (r_prod <= {2'b0, lim});
    assign val_nx = keep ? cand : r_val;

    // Square root digit step
    assign trial  = r_res + r_bit;
    assign take   = (r_v >= trial);
    assign res_nx = take ? (r_res >> 1) + r_bit : (r_res >> 1);

    assign m = (r_ax > r_ay) ? r_ax : r_ay;

    // Operand select for the shared multiplier
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            S_SQ: begin
                if (r_cnt < 5'd3) begin
                    mul_a = mg[r_cnt[1:0]];
                    mul_b = mg[r_cnt[1:0]];
                end else begin
                    mul_a = {1'b0, sp};
                    mul_b = {1'b0, sp};
                end
            end
            S_SQ2: begin
                mul_a = r_cnt[0] ? r_ay : r_ax;
                mul_b = r_cnt[0] ? r_ay : r_ax;
            end
            S_HALF: begin
                if (r_ph == 2'd0) begin
                    mul_a = {17'b0, tw[14:0]};
                    mul_b = {17'b0, tw[14:0]};
                end else begin
                    mul_a = r_prod[31:0];
                    mul_b = r_r;
                end
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_prod <= 64'(mul_a) * 64'(mul_b);
    end

    // Sequencer: length, count, per-axis step, heading
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_push) begin
                        r_start[0] <= i_start_x;
                        r_start[1] <= i_start_y;
                        r_start[2] <= i_start_z;
                        r_d[0] <= $signed({i_end_x[31], i_end_x})
                                  - $signed({i_start_x[31], i_start_x});
                        r_d[1] <= $signed({i_end_y[31], i_end_y})
                                  - $signed({i_start_y[31], i_start_y});
                        r_d[2] <= $signed({i_end_z[31], i_end_z})
                                  - $signed({i_start_z[31], i_start_z});
                        r_eq[0] <= i_end_qx;
                        r_eq[1] <= i_end_qy;
                        r_eq[2] <= i_end_qz;
                        r_eq[3] <= i_end_qw;
                        r_len2  <= '0;
                        r_cnt   <= '0;
                        r_state <= S_SQ;
                    end
                end
                S_SQ: begin
                    r_cnt <= r_cnt + 5'd1;
                    if (r_cnt != 5'd0 && r_cnt < 5'd4) begin
                        r_len2 <= r_len2 + 66'(r_prod);
                    end
                    if (r_cnt == 5'd4) begin
                        r_sp2   <= r_prod[61:0];
                        r_t2    <= 74'(r_prod);
                        r_u     <= 68'(r_prod);
                        r_k     <= 6'd1;
                        r_clamp <= 1'b0;
                        r_state <= S_NSRCH;
                    end
                end
                S_NSRCH: begin
                    if (r_t2 >= 74'(r_len2) || r_k == NW'(MaxSeg)) begin
                        r_n     <= r_k;
                        r_clamp <= (r_t2 < 74'(r_len2));
                        for (int a = 0; a < 3; a++) begin
                            r_dvd[a] <= mg[a];
                            r_rem[a] <= '0;
                        end
                        r_cnt   <= '0;
                        r_state <= S_DIV;
                    end else begin
                        r_t2 <= r_t2 + 74'({r_u, 1'b0}) + 74'(r_sp2);
                        r_u  <= r_u + 68'(r_sp2);
                        r_k  <= r_k + 6'd1;
                    end
                end
                S_DIV: begin
                    for (int a = 0; a < 3; a++) begin
                        logic [6:0] tr;
                        tr = {r_rem[a], r_dvd[a][31]};
                        if (tr >= {1'b0, r_n}) begin
                            r_rem[a] <= 6'(tr - {1'b0, r_n});
                            r_dvd[a] <= {r_dvd[a][30:0], 1'b1};
                        end else begin
                            r_rem[a] <= tr[5:0];
                            r_dvd[a] <= {r_dvd[a][30:0], 1'b0};
                        end
                    end
                    r_cnt <= r_cnt + 5'd1;
                    if (r_cnt == 5'd31) begin
                        r_ax <= mg[0];
                        r_ay <= mg[1];
                        if (mg[0] == '0 && mg[1] == '0) begin
                            r_qz    <= '0;
                            r_qw    <= QuatOne;
                            r_state <= S_PUSH;
                        end else begin
                            r_state <= S_NORM;
                        end
                    end
                end
                S_NORM: begin
                    if (m[31]) begin
                        r_ax <= r_ax >> 1;
                        r_ay <= r_ay >> 1;
                    end else if (!m[30]) begin
                        r_ax <= r_ax << 1;
                        r_ay <= r_ay << 1;
                    end else begin
                        r_cnt   <= '0;
                        r_state <= S_SQ2;
                    end
                end
                S_SQ2: begin
                    if (r_cnt == 5'd1) begin
                        r_v <= r_prod;
                    end
                    if (r_cnt == 5'd2) begin
                        r_v     <= r_v + r_prod;
                        r_res   <= '0;
                        r_bit   <= 64'd1 << 62;
                        r_cnt   <= '0;
                        r_state <= S_SQRT;
                    end else begin
                        r_cnt <= r_cnt + 5'd1;
                    end
                end
                S_SQRT: begin
                    if (take) begin
                        r_v <= r_v - trial;
                    end
                    r_res <= res_nx;
                    r_bit <= r_bit >> 2;
                    r_cnt <= r_cnt + 5'd1;
                    if (r_cnt == 5'd31) begin
                        r_r <= res_nx[31:0];
                        if (r_d[0][32]) begin
                            r_pos <= {1'b0, res_nx[31:0]} - {1'b0, r_ax};
                            r_neg <= {1'b0, res_nx[31:0]} + {1'b0, r_ax};
                        end else begin
                            r_pos <= {1'b0, res_nx[31:0]} + {1'b0, r_ax};
                            r_neg <= {1'b0, res_nx[31:0]} - {1'b0, r_ax};
                        end
                        r_val   <= '0;
                        r_b     <= 4'd14;
                        r_ph    <= '0;
                        r_h     <= 1'b0;
                        r_state <= S_HALF;
                    end
                end
                S_HALF: begin
                    if (r_ph == 2'd0 && cand <= 15'd16384) begin
                        r_ph <= 2'd1;
                    end else if (r_ph == 2'd1) begin
                        r_ph <= 2'd2;
                    end else begin
                        // Bit settled: advance, or close this term
                        r_ph <= 2'd0;
                        if (r_b == 4'd0) begin
                            r_val <= '0;
                            r_b   <= 4'd14;
                            if (!r_h) begin
                                r_qw <= {1'b0, val_nx};
                                r_h  <= 1'b1;
                            end else begin
                                r_qz    <= r_d[1][32] ? -{1'b0, val_nx} : {1'b0, val_nx};
                                r_state <= S_PUSH;
                            end
                        end else begin
                            r_val <= val_nx;
                            r_b   <= r_b - 4'd1;
                        end
                    end
                end
                S_PUSH: begin
                    if (!i_q_full) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_full   = (r_state != S_IDLE);
    assign o_q_push = (r_state == S_PUSH);

    // Assemble the segment word
    always_comb begin
        for (int a = 0; a < 3; a++) begin
            o_q_data.start[a] = r_start[a];
            o_q_data.neg[a]   = r_d[a][32];
            o_q_data.qd[a]    = r_dvd[a];
            o_q_data.rd[a]    = r_rem[a];
        end
        o_q_data.n       = r_n;
        o_q_data.clamped = r_clamp;
        o_q_data.qz      = r_qz;
        o_q_data.qw      = r_qw;
        o_q_data.eqx     = r_eq[0];
        o_q_data.eqy     = r_eq[1];
        o_q_data.eqz     = r_eq[2];
        o_q_data.eqw     = r_eq[3];
    end

endmodule

/* rtl/swsub_fifo.sv */
module swsub_fifo import swsub_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_seg i_data,
    output logic o_full,
    input  logic i_pop,
    output t_seg o_data,
    output logic o_empty
);

    t_seg       r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       wr, rd;

    assign wr = i_push && !o_full;
    assign rd = i_pop && !o_empty;

    // Hold up to two segment words
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (wr) begin
                r_wp <= ~r_wp;
            end
            if (rd) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(wr) - 2'(rd);
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_mem[r_wp] <= i_data;
        end
    end

    assign o_data  = r_mem[r_rp];
    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);

endmodule

/* rtl/swsub_back.sv */
module swsub_back import swsub_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_seg        i_q_data,
    input  logic        i_q_empty,
    output logic        o_q_pop,
    input  logic        i_pop,
    output logic        o_empty,
    output logic [31:0] o_point_x,
    output logic [31:0] o_point_y,
    output logic [31:0] o_point_z,
    output logic [15:0] o_quat_x,
    output logic [15:0] o_quat_y,
    output logic [15:0] o_quat_z,
    output logic [15:0] o_quat_w,
    output logic        o_last_point,
    output logic        o_count_clamped
);

    t_seg        r_seg;
    logic        r_active;
    logic [5:0]  r_k;
    logic [31:0] r_q   [3];
    logic [5:0]  r_rem [3];
    logic        r_ov;
    logic [31:0] r_pt  [3];
    logic [15:0] r_qt  [4];
    logic        r_last;
    logic        r_clamp;

    logic        load, last;
    logic [31:0] pt    [3];
    logic [31:0] q_nx  [3];
    logic [5:0]  rem_nx[3];

    assign o_q_pop = !r_active && !i_q_empty;
    assign load    = r_active && (!r_ov || i_pop);
    assign last    = (r_k == r_seg.n);

    // Point and next step, carrying the remainder of k*|d|/n
    always_comb begin
        for (int a = 0; a < 3; a++) begin
            logic [6:0] s;
            logic       c;
            pt[a] = r_seg.start[a] + (r_seg.neg[a] ? -r_q[a] : r_q[a]);
            s = {1'b0, r_rem[a]} + {1'b0, r_seg.rd[a]};
            c = (s >= {1'b0, r_seg.n});
            rem_nx[a] = c ? 6'(s - {1'b0, r_seg.n}) : s[5:0];
            q_nx[a]   = r_q[a] + r_seg.qd[a] + 32'(c);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_ov     <= 1'b0;
        end else begin
            // Hold the output word until popped, refill when a new one is made
            if (load) begin
                r_ov <= 1'b1;
            end else if (i_pop) begin
                r_ov <= 1'b0;
            end
            if (o_q_pop) begin
                r_seg    <= i_q_data;
                r_active <= 1'b1;
                r_k      <= '0;
                for (int a = 0; a < 3; a++) begin
                    r_q[a]   <= '0;
                    r_rem[a] <= '0;
                end
            end
            // Emit one word and advance
            if (load) begin
                r_last  <= last;
                r_clamp <= r_seg.clamped;
                for (int a = 0; a < 3; a++) begin
                    r_pt[a]  <= pt[a];
                    r_q[a]   <= q_nx[a];
                    r_rem[a] <= rem_nx[a];
                end
                if (last) begin
                    r_qt[0]  <= r_seg.eqx;
                    r_qt[1]  <= r_seg.eqy;
                    r_qt[2]  <= r_seg.eqz;
                    r_qt[3]  <= r_seg.eqw;
                    r_active <= 1'b0;
                end else begin
                    r_qt[0] <= '0;
                    r_qt[1] <= '0;
                    r_qt[2] <= r_seg.qz;
                    r_qt[3] <= r_seg.qw;
                    r_k     <= r_k + 6'd1;
                end
            end
        end
    end

    assign o_empty         = !r_ov;
    assign o_point_x       = r_pt[0];
    assign o_point_y       = r_pt[1];
    assign o_point_z       = r_pt[2];
    assign o_quat_x        = r_qt[0];
    assign o_quat_y        = r_qt[1];
    assign o_quat_z        = r_qt[2];
    assign o_quat_w        = r_qt[3];
    assign o_last_point    = r_last;
    assign o_count_clamped = r_clamp;

endmodule

/* rtl/segment_waypoint_subdivider_top.sv */
// Segment waypoint subdivider.
// Input queue side: present a segment (start, end, end orientation) with push;
// it is taken on a clock edge where push is high and full is low.
// Result queue side: while empty is low the oldest waypoint word sits on the
// o_ ports; pop takes it. A segment of n parts gives n+1 words, the last
// flagged by o_last_point and carrying the end orientation.
// Spacing is written through i_spacing_we / i_spacing; the user must write it
// only while the block idles, and the block itself does not enforce this.
// The front end takes one segment at a time: the squared length, the count
// search, the per-axis divide, normalising, the square root and the two
// half-angle searches on the shared multiplier; normalising, the root and
// the searches are skipped when the horizontal delta is zero. A two-word
// segment queue lets it start the next segment while the emitter still
// streams; within a segment the emitter gives one word per cycle while pop
// keeps up. When the receiver stalls, the output word holds and both queues
// back up until full rises. Reset empties every queue and sets spacing to 1 m.
module segment_waypoint_subdivider_top import swsub_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_spacing_we,
    input  logic [30:0] i_spacing,
    input  logic        push,
    output logic        full,
    input  logic [31:0] i_start_x,
    input  logic [31:0] i_start_y,
    input  logic [31:0] i_start_z,
    input  logic [31:0] i_end_x,
    input  logic [31:0] i_end_y,
    input  logic [31:0] i_end_z,
    input  logic [15:0] i_end_qx,
    input  logic [15:0] i_end_qy,
    input  logic [15:0] i_end_qz,
    input  logic [15:0] i_end_qw,
    output logic        empty,
    input  logic        pop,
    output logic [31:0] o_point_x,
    output logic [31:0] o_point_y,
    output logic [31:0] o_point_z,
    output logic [15:0] o_quat_x,
    output logic [15:0] o_quat_y,
    output logic [15:0] o_quat_z,
    output logic [15:0] o_quat_w,
    output logic        o_last_point,
    output logic        o_count_clamped
);

    logic [30:0] r_spacing;
    logic        f_push, f_full, f_pop, f_empty;
    t_seg        f_in, f_out;

    // Hold the spacing register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_spacing <= SpacingReset;
        end else if (i_spacing_we) begin
            r_spacing <= i_spacing;
        end
    end

    swsub_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_spacing (r_spacing),
        .i_push    (push),
        .o_full    (full),
        .i_start_x (i_start_x),
        .i_start_y (i_start_y),
        .i_start_z (i_start_z),
        .i_end_x   (i_end_x),
        .i_end_y   (i_end_y),
        .i_end_z   (i_end_z),
        .i_end_qx  (i_end_qx),
        .i_end_qy  (i_end_qy),
        .i_end_qz  (i_end_qz),
        .i_end_qw  (i_end_qw),
        .o_q_push  (f_push),
        .i_q_full  (f_full),
        .o_q_data  (f_in)
    );

    swsub_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_push),
        .i_data  (f_in),
        .o_full  (f_full),
        .i_pop   (f_pop),
        .o_data  (f_out),
        .o_empty (f_empty)
    );

    swsub_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_q_data        (f_out),
        .i_q_empty       (f_empty),
        .o_q_pop         (f_pop),
        .i_pop           (pop),
        .o_empty         (empty),
        .o_point_x       (o_point_x),
        .o_point_y       (o_point_y),
        .o_point_z       (o_point_z),
        .o_quat_x        (o_quat_x),
        .o_quat_y        (o_quat_y),
        .o_quat_z        (o_quat_z),
        .o_quat_w        (o_quat_w),
        .o_last_point    (o_last_point),
        .o_count_clamped (o_count_clamped)
    );

    // The front end only raises its segment push while it is busy (full high)
    a_push_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        f_push |-> full)
        else $error("segment push while front end idle");

    // The emitter only draws a segment that is present
    a_pop_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        f_pop |-> !f_empty)
        else $error("segment pop from empty queue");

    // Intermediate waypoints carry a yaw-only orientation
    a_yaw_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !o_last_point) |-> (o_quat_x == '0 && o_quat_y == '0))
        else $error("tilt on intermediate waypoint");

endmodule

/* verif/testbench.sv */
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import swsub_pkg::*;

    // One segment as presented on the input side
    typedef struct packed {
        logic signed [31:0] sx, sy, sz, ex, ey, ez;
        logic signed [15:0] qx, qy, qz, qw;
    } t_seg_in;

    // One waypoint word as seen on the result side
    typedef struct packed {
        logic [31:0] px, py, pz;
        logic [15:0] qx, qy, qz, qw;
        logic        last;
        logic        clamped;
    } t_waypoint;

    // Directed row: segment plus the word count where it is plain to see (0: not typed)
    typedef struct packed {
        t_seg_in    seg;
        logic [7:0] words;
    } t_seg_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_spacing_we = 1'b0;
    logic [30:0] i_spacing = '0;
    logic        push = 1'b0;
    logic        full;
    t_seg_in     seg_in = '0;
    logic        empty;
    logic        pop = 1'b0;
    t_waypoint   wp_out;

    segment_waypoint_subdivider_top dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_spacing_we   (i_spacing_we),
        .i_spacing      (i_spacing),
        .push           (push),
        .full           (full),
        .i_start_x      (seg_in.sx),
        .i_start_y      (seg_in.sy),
        .i_start_z      (seg_in.sz),
        .i_end_x        (seg_in.ex),
        .i_end_y        (seg_in.ey),
        .i_end_z        (seg_in.ez),
        .i_end_qx       (seg_in.qx),
        .i_end_qy       (seg_in.qy),
        .i_end_qz       (seg_in.qz),
        .i_end_qw       (seg_in.qw),
        .empty          (empty),
        .pop            (pop),
        .o_point_x      (wp_out.px),
        .o_point_y      (wp_out.py),
        .o_point_z      (wp_out.pz),
        .o_quat_x       (wp_out.qx),
        .o_quat_y       (wp_out.qy),
        .o_quat_z       (wp_out.qz),
        .o_quat_w       (wp_out.qw),
        .o_last_point   (wp_out.last),
        .o_count_clamped(wp_out.clamped)
    );

    localparam logic signed [31:0] PosMax = 32'sh7FFFFFFF;
    localparam logic signed [31:0] PosMin = 32'sh80000000;
    localparam logic signed [31:0] Metre  = 32'sd65536;
    localparam logic signed [15:0] QOne   = 16'sd16384;

    t_waypoint   waypoints_due[$];
    logic [30:0] spacing_now = SpacingReset;
    int          gap_pct = 0;
    int          stall_pct = 0;
    int          mismatches = 0;
    int          segments_sent = 0;
    int          words_seen = 0;
    int          clamped_seen = 0;

    // Clock: 12 ns period
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Nearest integer to 16384 * sqrt(num / (2r)), exact halves up
    function automatic logic [63:0] half_angle(logic [63:0] num, logic [63:0] r);
        logic [63:0] lo, hi, mid, t;
        lo = 0;
        hi = 16384;
        while (lo < hi) begin
            mid = (lo + hi + 1) >> 1;
            t   = 2 * mid - 1;
            if (t * t * r <= (num << 29)) lo = mid;
            else hi = mid - 1;
        end
        return lo;
    endfunction

    // Work out the waypoint words of one segment and queue them
    function automatic int predict_waypoints(t_seg_in g);
        longint      dl[3], sl[3], off;
        logic [63:0] mg, ax, ay, mx, r, pos, neg, v, res, bt;
        logic [63:0] qz, qw, sp;
        logic [127:0] len2, tt;
        int          n, a;
        bit          clamped;
        t_waypoint   w;
        sl[0] = longint'(g.sx);
        sl[1] = longint'(g.sy);
        sl[2] = longint'(g.sz);
        dl[0] = longint'(g.ex) - sl[0];
        dl[1] = longint'(g.ey) - sl[1];
        dl[2] = longint'(g.ez) - sl[2];
        sp = (spacing_now == 0) ? 64'd1 : 64'(spacing_now);
        len2 = 0;
        for (a = 0; a < 3; a++) begin
            mg = (dl[a] < 0) ? 64'(-dl[a]) : 64'(dl[a]);
            len2 += 128'(mg) * 128'(mg);
        end
        // smallest count whose span covers the length
        n = 0;
        for (int k = 1; k <= MaxSeg; k++) begin
            tt = 128'(k) * 128'(sp);
            if (n == 0 && tt * tt >= len2) n = k;
        end
        clamped = (n == 0);
        if (clamped) n = MaxSeg;
        // heading from the normalised horizontal delta
        qz = 0;
        qw = 16384;
        ax = (dl[0] < 0) ? 64'(-dl[0]) : 64'(dl[0]);
        ay = (dl[1] < 0) ? 64'(-dl[1]) : 64'(dl[1]);
        mx = (ax > ay) ? ax : ay;
        if (mx != 0) begin
            while (mx >= 64'h8000_0000) begin
                ax >>= 1; ay >>= 1; mx >>= 1;
            end
            while (mx < 64'h4000_0000) begin
                ax <<= 1; ay <<= 1; mx <<= 1;
            end
            v   = ax * ax + ay * ay;
            res = 0;
            bt  = 64'd1 << 62;
            while (bt > v) bt >>= 2;
            while (bt != 0) begin
                if (v >= res + bt) begin
                    v   = v - (res + bt);
                    res = (res >> 1) + bt;
                end else begin
                    res = res >> 1;
                end
                bt >>= 2;
            end
            r = res;
            if (dl[0] >= 0) begin
                pos = r + ax; neg = r - ax;
            end else begin
                pos = r - ax; neg = r + ax;
            end
            qw = half_angle(pos, r);
            qz = half_angle(neg, r);
            if (dl[1] < 0) qz = -qz;
        end
        for (int i = 0; i <= n; i++) begin
            off  = (longint'(i) * dl[0]) / longint'(n);
            w.px = 32'(sl[0] + off);
            off  = (longint'(i) * dl[1]) / longint'(n);
            w.py = 32'(sl[1] + off);
            off  = (longint'(i) * dl[2]) / longint'(n);
            w.pz = 32'(sl[2] + off);
            if (i == n) begin
                w.qx = g.qx; w.qy = g.qy; w.qz = g.qz; w.qw = g.qw;
            end else begin
                w.qx = 0; w.qy = 0; w.qz = qz[15:0]; w.qw = qw[15:0];
            end
            w.last    = (i == n);
            w.clamped = clamped;
            waypoints_due = {waypoints_due, w};
        end
        return n + 1;
    endfunction

    // Random segment: mostly deltas of a random scale, some wholly random ends
    function automatic t_seg_in random_segment();
        t_seg_in g;
        g.sx = $urandom;
        g.sy = $urandom;
        g.sz = $urandom;
        if ($urandom_range(7) == 0) begin
            g.ex = $urandom; g.ey = $urandom; g.ez = $urandom;
        end else begin
            g.ex = g.sx + ($signed($urandom) >>> $urandom_range(31, 4));
            g.ey = g.sy + ($signed($urandom) >>> $urandom_range(31, 4));
            g.ez = g.sz + ($signed($urandom) >>> $urandom_range(31, 4));
        end
        g.qx = 16'($urandom_range(32768)) - QOne;
        g.qy = 16'($urandom_range(32768)) - QOne;
        g.qz = 16'($urandom_range(32768)) - QOne;
        g.qw = 16'($urandom_range(32768)) - QOne;
        return g;
    endfunction

    // Present one segment, hold it until taken, then queue its waypoints
    task automatic send_segment(t_seg_in g, int words);
        int n_words;
        while ($urandom_range(99) < gap_pct) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push   <= 1'b1;
        seg_in <= g;
        do @(posedge i_clk); while (full);
        n_words = predict_waypoints(g);
        segments_sent++;
        if (words != 0 && words != n_words) begin
            mismatches++;
            if (mismatches <= 10)
                $display("segment %0d: %0d words predicted, %0d expected",
                         segments_sent, n_words, words);
        end
    endtask

    // Hold input off until every waypoint is out, then let the front end settle
    task automatic drain();
        push <= 1'b0;
        while (waypoints_due.size() != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
    endtask

    task automatic write_spacing(logic [30:0] v);
        drain();
        i_spacing_we <= 1'b1;
        i_spacing    <= v;
        @(posedge i_clk);
        i_spacing_we <= 1'b0;
        spacing_now = v;
    endtask

    // Result side: check each word taken, then pick the next pop
    always @(posedge i_clk) begin
        if (i_rst_n && pop && !empty) begin
            words_seen++;
            if (wp_out.clamped) clamped_seen++;
            if (waypoints_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected word %h", wp_out);
            end else begin
                if (wp_out !== waypoints_due[0]) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("word %0d: expected %h, got %h",
                                 words_seen, waypoints_due[0], wp_out);
                end
                void'(waypoints_due.pop_front());
            end
        end
        pop <= ($urandom_range(99) >= stall_pct);
    end

    t_seg_row directed_rows[] = '{
        // zero length at the origin and at the top corner
        '{'{32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0,
            16'sd0, 16'sd0, 16'sd0, QOne}, 8'd2},
        '{'{PosMax, PosMax, PosMax, PosMax, PosMax, PosMax,
            QOne, QOne, QOne, QOne}, 8'd2},
        // full-width runs along x clamp the count
        '{'{PosMin, 32'sd0, 32'sd0, PosMax, 32'sd0, 32'sd0,
            -QOne, -QOne, -QOne, -QOne}, 8'd64},
        '{'{PosMax, 32'sd0, 32'sd0, PosMin, 32'sd0, 32'sd0,
            16'sd0, 16'sd0, 16'sd0, QOne}, 8'd64},
        // along -x with dy zero, and along +y / -y
        '{'{32'sd0, 32'sd0, 32'sd0, -4 * Metre, 32'sd0, 32'sd0,
            16'sd0, 16'sd0, QOne, 16'sd0}, 8'd5},
        '{'{32'sd0, 32'sd0, 32'sd0, 32'sd0, 10 * Metre, 32'sd0,
            16'sd0, 16'sd0, 16'sd11585, 16'sd11585}, 8'd11},
        '{'{32'sd0, 32'sd0, 32'sd0, 32'sd0, -10 * Metre, 32'sd0,
            16'sd0, 16'sd0, -16'sd11585, 16'sd11585}, 8'd11},
        // short run, exact spacing multiple and one lsb beyond
        '{'{32'sd0, 32'sd0, 32'sd0, Metre / 2, 32'sd0, 32'sd0,
            16'sd0, 16'sd0, 16'sd0, QOne}, 8'd2},
        '{'{32'sd0, 32'sd0, 32'sd0, 3 * Metre, 32'sd0, 32'sd0,
            16'sd0, 16'sd0, 16'sd0, QOne}, 8'd4},
        '{'{32'sd0, 32'sd0, 32'sd0, 3 * Metre + 1, 32'sd0, 32'sd0,
            16'sd0, 16'sd0, 16'sd0, QOne}, 8'd5},
        // 3-4-5 diagonal, vertical only (zero horizontal delta)
        '{'{Metre, -Metre, 32'sd7, 4 * Metre, 3 * Metre, 32'sd7,
            16'sd100, -16'sd100, 16'sd200, 16'sd300}, 8'd6},
        '{'{32'sd5, 32'sd5, -Metre, 32'sd5, 32'sd5, 6 * Metre,
            16'sd0, 16'sd0, 16'sd0, QOne}, 8'd8},
        // offsets that truncate toward zero, just over 10 m long
        '{'{32'sd0, 32'sd0, 32'sd0, -32'sd7, 10 * Metre, -32'sd13,
            16'sd1, 16'sd2, 16'sd3, 16'sd4}, 8'd12},
        // corner to corner on every axis
        '{'{PosMin, PosMin, PosMin, PosMax, PosMax, PosMax,
            16'sh5555, 16'sh2AAA, -16'sd1, 16'sd0}, 8'd64},
        '{'{PosMax, PosMin, PosMax, PosMin, PosMax, PosMin,
            -16'sd1, 16'sh2AAA, 16'sh1555, -QOne}, 8'd64},
        // odd directions: heading rounding, not typed
        '{'{32'sd0, 32'sd0, 32'sd0, -3 * Metre, -32'sd1, 32'sd0,
            16'sd0, 16'sd0, 16'sd0, QOne}, 8'd0},
        '{'{32'sd1234567, -32'sd7654321, 32'sd0, -32'sd1, 32'sd99, 32'sd3,
            16'sd0, 16'sd0, 16'sd0, QOne}, 8'd0},
        '{'{32'sd0, 32'sd0, 32'sd0, 32'sd1, -32'sd1, 32'sd0,
            16'sd0, 16'sd0, 16'sd0, QOne}, 8'd0}
    };

    // Main sequence: reset, directed rows, then random phases over several spacings
    initial begin
        logic [30:0] phase_spacing[4];
        phase_spacing[0] = 31'd1;
        phase_spacing[1] = 31'h7FFF_FFFF;
        phase_spacing[2] = 31'd0;
        phase_spacing[3] = 31'($urandom_range(32'h0040_0000, 32'h0000_4000));
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[i]) send_segment(directed_rows[i].seg, directed_rows[i].words);

        for (int ph = 0; ph < 4; ph++) begin
            write_spacing(phase_spacing[ph]);
            gap_pct   = (ph == 1) ? 80 : (ph == 3) ? 28 : 0;
            stall_pct = (ph == 2) ? 80 : (ph == 3) ? 28 : 0;
            for (int i = 0; i < 38; i++) send_segment(random_segment(), 0);
        end
        // unstalled tail at the default-like spacing
        write_spacing(31'd65536);
        gap_pct   = 0;
        stall_pct = 0;
        for (int i = 0; i < 10; i++) send_segment(random_segment(), 0);
        drain();

        $display("%0d segments sent, %0d waypoint words checked (%0d clamped)",
                 segments_sent, words_seen, clamped_seen);
        $display("spacings 1 m, 1 lsb, max, zero and random; idle and stall mixes applied");
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    // Guard against a hung handshake
    initial begin
        #(12 * 2_000_000);
        $display("Mismatches found");
        $finish;
    end

endmodule
